FILE: sv/integer_to_ascii_radix_macros.svh
// ---------------------------------------------------------------------------
// integer_to_ascii_radix assertion macros
// Shorthand for clocked implication checks, disabled while the active-low
// reset is low; used by the port checker.
// ---------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_RADIX_MACROS_SVH
`define INTEGER_TO_ASCII_RADIX_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("itoar: port check failed");

// Next-cycle implication.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("itoar: port check failed");

`endif

FILE: sv/itoar_pkg.sv
// ---------------------------------------------------------------------------
// itoar_pkg
// Types, constants and helpers shared by the integer-to-ASCII converter.
// ---------------------------------------------------------------------------
package itoar_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int RADIX_WIDTH = 5;
    localparam int CHAR_WIDTH  = 7;
    localparam int DIG_WIDTH   = 4;

    // Divider retires this many quotient bits per cycle.
    localparam int CHUNK       = 8;
    localparam int NCHUNK      = (VALUE_WIDTH + CHUNK - 1) / CHUNK;
    localparam int DIV_WIDTH   = NCHUNK * CHUNK;
    localparam int STEP_WIDTH  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

    // At most one digit per magnitude bit.
    localparam int DIG_DEPTH   = VALUE_WIDTH;
    localparam int DIG_AW      = $clog2(DIG_DEPTH);

    localparam logic [RADIX_WIDTH-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_WIDTH-1:0] RADIX_MAX = 5'd16;
    localparam logic [RADIX_WIDTH-1:0] RADIX_BIN = 5'd2;
    localparam logic [RADIX_WIDTH-1:0] RADIX_QUA = 5'd4;
    localparam logic [RADIX_WIDTH-1:0] RADIX_OCT = 5'd8;
    localparam logic [RADIX_WIDTH-1:0] RADIX_DEC = 5'd10;
    localparam logic [RADIX_WIDTH-1:0] RADIX_HEX = 5'd16;

    localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_WIDTH-1:0] CH_UPA   = 7'h41;
    localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 7'h2D;
    localparam logic [CHAR_WIDTH-1:0] CH_X     = 7'h78;
    localparam logic [CHAR_WIDTH-1:0] CH_O     = 7'h6F;
    localparam logic [CHAR_WIDTH-1:0] CH_B     = 7'h62;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] value;
        logic [RADIX_WIDTH-1:0]        radix;
    } t_req;

    typedef struct packed {
        logic [CHAR_WIDTH-1:0] char_code;
        logic                  last;
    } t_rsp;

    // Controller -> datapath
    typedef struct packed {
        logic load;       // capture request
        logic divide;     // work on current digit
        logic emit_pfx0;  // '0' or '-'
        logic emit_pfx1;  // 'x', 'o' or 'b'
        logic rd;         // read next stored digit
        logic rd_last;    // this read is the final character
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic digit_done; // digit written this cycle
        logic quo_zero;   // remaining magnitude is zero
        logic has_pfx0;
        logic has_pfx1;
        logic rd_zero;    // read pointer at least significant digit
    } t_dp_stat;

    function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [DIG_WIDTH-1:0] d);
        logic [CHAR_WIDTH-1:0] dx;
        dx = CHAR_WIDTH'(d);
        if (d < 4'd10) begin
            return CH_ZERO + dx;
        end else begin
            return CH_UPA + dx - 7'd10;
        end
    endfunction

endpackage

FILE: sv/itoar_ram.sv
// ---------------------------------------------------------------------------
// itoar_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module itoar_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/itoar_ctrl.sv
// ---------------------------------------------------------------------------
// itoar_ctrl
// Sequencer: digit extraction, prefix emission, digit readout.
// ---------------------------------------------------------------------------
module itoar_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  itoar_pkg::t_dp_stat i_stat,
    output itoar_pkg::t_dp_cmd  o_cmd,
    output logic               o_busy
);
    import itoar_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_PFX0,
        S_PFX1,
        S_READ,
        S_DRAIN
    } t_state;

    t_state r_state, n_state;
    logic   r_busy,  n_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.divide = 1'b1;
                if (i_stat.digit_done && i_stat.quo_zero) begin
                    n_state = i_stat.has_pfx0 ? S_PFX0 : S_READ;
                end
            end
            S_PFX0: begin
                o_cmd.emit_pfx0 = 1'b1;
                n_state = i_stat.has_pfx1 ? S_PFX1 : S_READ;
            end
            S_PFX1: begin
                o_cmd.emit_pfx1 = 1'b1;
                n_state = S_READ;
            end
            S_READ: begin
                o_cmd.rd      = 1'b1;
                o_cmd.rd_last = i_stat.rd_zero;
                if (i_stat.rd_zero) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_busy = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign o_busy = r_busy;

endmodule

FILE: sv/itoar_dp.sv
// ---------------------------------------------------------------------------
// itoar_dp
// Magnitude register, chunked radix divider, digit store and output register.
// ---------------------------------------------------------------------------
module itoar_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  itoar_pkg::t_req     i_req,
    input  itoar_pkg::t_dp_cmd  i_cmd,
    output itoar_pkg::t_dp_stat o_stat,
    output logic                o_strobe,
    output itoar_pkg::t_rsp     o_rsp
);
    import itoar_pkg::*;

    // request capture
    logic [RADIX_WIDTH-1:0] r_base;
    logic                   r_neg;
    logic                   r_pow2;
    logic [2:0]             r_shift;
    logic [DIG_WIDTH-1:0]   r_mask;

    // divider
    logic [DIV_WIDTH-1:0]   r_div;
    logic [DIV_WIDTH-1:0]   r_quo;
    logic [DIG_WIDTH-1:0]   r_rem;
    logic [STEP_WIDTH-1:0]  r_step;

    // digit store pointers
    logic [DIG_AW-1:0]      r_wr_idx;
    logic [DIG_AW-1:0]      r_rd_idx;

    // output pipe
    logic                   r_rd_pend;
    logic                   r_rd_last;
    logic                   r_out_valid;
    logic [CHAR_WIDTH-1:0]  r_out_char;
    logic                   r_out_last;

    logic [VALUE_WIDTH-1:0] in_raw;
    logic [VALUE_WIDTH-1:0] in_mag;
    logic [RADIX_WIDTH-1:0] in_base;
    logic                   in_pow2;
    logic [2:0]             in_shift;

    logic [CHUNK-1:0]       q_chunk;
    logic [DIG_WIDTH-1:0]   rem_next;
    logic [DIV_WIDTH-1:0]   quo_full;
    logic                   step_last;
    logic                   digit_done;
    logic [DIG_WIDTH-1:0]   dig_val;
    logic [DIV_WIDTH-1:0]   next_div;
    logic [DIG_WIDTH-1:0]   ram_rdata;

    // Request decode: magnitude, clamped base, shift for power-of-two bases.
    always_comb begin
        in_raw = i_req.value;
        in_mag = in_raw[VALUE_WIDTH-1] ? (~in_raw + 1'b1) : in_raw;
        if (i_req.radix < RADIX_MIN) begin
            in_base = RADIX_MIN;
        end else if (i_req.radix > RADIX_MAX) begin
            in_base = RADIX_MAX;
        end else begin
            in_base = i_req.radix;
        end
        in_pow2  = 1'b1;
        in_shift = 3'd1;
        case (in_base)
            RADIX_BIN: in_shift = 3'd1;
            RADIX_QUA: in_shift = 3'd2;
            RADIX_OCT: in_shift = 3'd3;
            RADIX_HEX: in_shift = 3'd4;
            default:   in_pow2  = 1'b0;
        endcase
    end

    // One chunk of restoring division; remainder stays below the base.
    always_comb begin
        logic [DIG_WIDTH:0] t;
        logic [DIG_WIDTH-1:0] rv;
        rv      = r_rem;
        q_chunk = '0;
        for (int i = 0; i < CHUNK; i++) begin
            t = {rv, r_div[DIV_WIDTH-1-i]};
            if (t >= r_base) begin
                q_chunk[CHUNK-1-i] = 1'b1;
                t = t - r_base;
            end
            rv = t[DIG_WIDTH-1:0];
        end
        rem_next = rv;
    end

    assign quo_full   = DIV_WIDTH'({r_quo, q_chunk});
    assign step_last  = (r_step == STEP_WIDTH'(NCHUNK - 1));
    assign digit_done = i_cmd.divide && (r_pow2 || step_last);
    assign dig_val    = r_pow2 ? (r_div[DIG_WIDTH-1:0] & r_mask) : rem_next;
    assign next_div   = r_pow2 ? (r_div >> r_shift) : quo_full;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base   <= in_base;
            r_neg    <= in_raw[VALUE_WIDTH-1];
            r_pow2   <= in_pow2;
            r_shift  <= in_shift;
            r_mask   <= DIG_WIDTH'(in_base - 1'b1);
            r_div    <= DIV_WIDTH'(in_mag);
            r_rem    <= '0;
            r_step   <= '0;
            r_wr_idx <= '0;
        end else if (i_cmd.divide) begin
            if (digit_done) begin
                r_div    <= next_div;
                r_rem    <= '0;
                r_step   <= '0;
                r_rd_idx <= r_wr_idx;
                r_wr_idx <= r_wr_idx + 1'b1;
            end else begin
                r_div  <= r_div << CHUNK;
                r_quo  <= quo_full;
                r_rem  <= rem_next;
                r_step <= r_step + 1'b1;
            end
        end else if (i_cmd.rd) begin
            r_rd_idx <= r_rd_idx - 1'b1;
        end
    end

    itoar_ram #(
        .WIDTH (DIG_WIDTH),
        .DEPTH (DIG_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (digit_done),
        .i_waddr (r_wr_idx),
        .i_wdata (dig_val),
        .i_re    (i_cmd.rd),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    // Output register; prefix and digit reads never land in the same cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_pend   <= i_cmd.rd;
            r_out_valid <= i_cmd.emit_pfx0 || i_cmd.emit_pfx1 || r_rd_pend;
        end
        r_rd_last  <= i_cmd.rd_last;
        r_out_last <= r_rd_pend && r_rd_last;
        if (i_cmd.emit_pfx0) begin
            r_out_char <= (r_base == RADIX_DEC) ? CH_MINUS : CH_ZERO;
        end else if (i_cmd.emit_pfx1) begin
            case (r_base)
                RADIX_HEX: r_out_char <= CH_X;
                RADIX_OCT: r_out_char <= CH_O;
                default:   r_out_char <= CH_B;
            endcase
        end else begin
            r_out_char <= digit_char(ram_rdata);
        end
    end

    always_comb begin
        o_stat.digit_done = digit_done;
        o_stat.quo_zero   = (next_div == '0);
        o_stat.has_pfx0   = (r_base != RADIX_DEC) || r_neg;
        o_stat.has_pfx1   = (r_base == RADIX_HEX) || (r_base == RADIX_OCT) ||
                            (r_base == RADIX_BIN);
        o_stat.rd_zero    = (r_rd_idx == '0);
    end

    assign o_strobe        = r_out_valid;
    assign o_rsp.char_code = r_out_char;
    assign o_rsp.last      = r_out_last;

endmodule

FILE: sv/integer_to_ascii_radix.sv
// ---------------------------------------------------------------------------
// integer_to_ascii_radix
// Signed integer to ASCII text in bases 2 to 16, one character per strobe.
// ---------------------------------------------------------------------------
// A request (value, radix) is taken when start is high and busy is low. The
// block then emits the text MSD first: a prefix ("-" for negative decimal,
// "0x"/"0o"/"0b" for bases 16/8/2, "0" for other non-decimal bases), then
// the digits in uppercase 0-9A-F. Non-decimal negatives print the magnitude.
// Radix values outside 2..16 are clamped. Each character is valid for one
// cycle with o_strobe high; there is no backpressure, so the receiver must
// take every strobe. o_rsp.last marks the final character, and busy drops in
// that same cycle, so the next request may be taken at the edge that ends it.
// Digits for bases 2, 4, 8 and 16 are bit slices of the magnitude; other
// bases use the shared divider, which retires 8 quotient bits per cycle
// over the 32-bit magnitude. The prefix is 0 to 2 characters long.
// Digits are produced LSD first into a small digit RAM and read back MSD
// first, one per cycle. After a prefix, strobes pause before the first digit.
// ---------------------------------------------------------------------------
module integer_to_ascii_radix (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  itoar_pkg::t_req i_req,
    output logic            busy,
    output logic            o_strobe,
    output itoar_pkg::t_rsp o_rsp
);
    import itoar_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequencer: decides which phase the datapath is in.
    itoar_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (busy)
    );

    // Datapath: divider, digit store, output register.
    itoar_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (dp_cmd),
        .o_stat   (dp_stat),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

endmodule

FILE: sv/itoar_chk.sv
// ---------------------------------------------------------------------------
// itoar_chk
// Port-level checks on request/result sequencing, bound to the top level.
// ---------------------------------------------------------------------------
`include "integer_to_ascii_radix_macros.svh"

module itoar_chk (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            start,
    input logic            busy,
    input logic            o_strobe,
    input itoar_pkg::t_rsp o_rsp
);
    import itoar_pkg::*;

    // accepted request keeps the block busy
    `ASSERT_NXT(a_req_busy, i_clk, i_rst_n, start && !busy, busy)
    // final character coincides with busy release
    `ASSERT_IMP(a_last_idle, i_clk, i_rst_n, o_strobe && o_rsp.last, !busy)
    // a non-final character only shows while the request is still running
    `ASSERT_IMP(a_more_busy, i_clk, i_rst_n, o_strobe && !o_rsp.last, busy)
    // no spurious character out of idle
    `ASSERT_NXT(a_idle_quiet, i_clk, i_rst_n, !busy && !o_strobe, !o_strobe)

endmodule

bind integer_to_ascii_radix itoar_chk u_chk (.*);
